// ----- rtl/core/xed_pkg.sv -----
// Shared types, character codes and UTF-8 helpers for the XML entity decoder.
// No dependencies.
`timescale 1ns / 1ps

package xed_pkg;

   localparam int XED_QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;

   localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
   localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
   localparam logic [31:0] NAME_GT   = 32'h0000_6774;
   localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;
   localparam logic [31:0] NAME_APOS = 32'h6170_6F73;

   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] CP_ONE_MAX  = 21'h00007F;
   localparam logic [20:0] CP_TWO_MAX  = 21'h0007FF;
   localparam logic [20:0] CP_THREE_MAX = 21'h00FFFF;

   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF_CONT  = 8'h80;
   localparam logic [5:0] UTF_MASK  = 6'h3F;

   typedef enum logic [2:0] {
      PH_PLAIN,
      PH_NAME,
      PH_HASH,
      PH_DEC,
      PH_HEX,
      PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      JOB_RAW,
      JOB_CODE,
      JOB_ERROR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [20:0]  value;
      logic         last;
   } job_type;

   // Number of UTF-8 bytes minus one for a legal code point.
   function automatic logic [1:0] utf8_span(input logic [20:0] cp);
      logic [1:0] span;
      if (cp <= CP_ONE_MAX) begin
         span = 2'd0;
      end else if (cp <= CP_TWO_MAX) begin
         span = 2'd1;
      end else if (cp <= CP_THREE_MAX) begin
         span = 2'd2;
      end else begin
         span = 2'd3;
      end
      return span;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] span,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = cp[7:0];
      case (span)
         2'd0: b = cp[7:0];
         2'd1: begin
            case (idx)
               2'd0:    b = UTF_LEAD2 | {3'b000, cp[10:6]};
               default: b = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
            endcase
         end
         2'd2: begin
            case (idx)
               2'd0:    b = UTF_LEAD3 | {4'b0000, cp[15:12]};
               2'd1:    b = UTF_CONT | {2'b00, cp[11:6]};
               default: b = UTF_CONT | {2'b00, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = UTF_LEAD4 | {5'b00000, cp[20:18]};
               2'd1:    b = UTF_CONT | {2'b00, cp[17:12]};
               2'd2:    b = UTF_CONT | {2'b00, cp[11:6]};
               default: b = UTF_CONT | {2'b00, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/xed_front.sv -----
// Front end: entity/reference parser, one byte per cycle while the job queue is not full, emits decode jobs.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             is_last,
   output logic             push_valid,
   output xed_pkg::job_type push_job
);
   import xed_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [31:0] name_ff,    name_in;
   logic [2:0]  len_ff,     len_in;
   logic [20:0] code_ff,    code_in;
   logic        ovf_ff,     ovf_in;
   logic        digit_ff,   digit_in;

   logic        is_hex_digit;
   logic        dig_ok;
   logic [3:0]  dig_val;
   logic [24:0] acc_next;
   logic        named_ok;
   logic [7:0]  named_char;

   always_comb begin
      is_hex_digit = (phase_ff == PH_HEX);
      dig_ok  = 1'b0;
      dig_val = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         dig_ok  = 1'b1;
         dig_val = in_byte[3:0];
      end else if (is_hex_digit && (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
         dig_ok  = 1'b1;
         dig_val = in_byte[3:0] + 4'd9;
      end
      if (is_hex_digit) begin
         acc_next = {code_ff, 4'b0000} | {21'd0, dig_val};
      end else begin
         acc_next = {1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + {21'd0, dig_val};
      end
   end

   always_comb begin
      named_ok   = 1'b1;
      named_char = CH_AMP;
      if (len_ff == 3'd3 && name_ff == NAME_AMP) begin
         named_char = CH_AMP;
      end else if (len_ff == 3'd2 && name_ff == NAME_LT) begin
         named_char = CH_LT;
      end else if (len_ff == 3'd2 && name_ff == NAME_GT) begin
         named_char = CH_GT;
      end else if (len_ff == 3'd4 && name_ff == NAME_QUOT) begin
         named_char = CH_QUOT;
      end else if (len_ff == 3'd4 && name_ff == NAME_APOS) begin
         named_char = CH_APOS;
      end else begin
         named_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      name_in    = name_ff;
      len_in     = len_ff;
      code_in    = code_ff;
      ovf_in     = ovf_ff;
      digit_in   = digit_ff;
      push_valid = 1'b0;
      push_job   = '{kind: JOB_RAW, value: {13'd0, in_byte}, last: 1'b0};

      if (accept) begin
         case (phase_ff)
            PH_FAIL: begin
            end
            PH_NAME: begin
               if (in_byte == CH_SEMI) begin
                  if (named_ok) begin
                     push_valid     = 1'b1;
                     push_job.value = {13'd0, named_char};
                     phase_in       = PH_PLAIN;
                     name_in        = '0;
                     len_in         = '0;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end else if (in_byte == CH_HASH && len_ff == 3'd0) begin
                  phase_in = PH_HASH;
               end else if (len_ff >= 3'd4) begin
                  phase_in = PH_FAIL;
               end else begin
                  name_in = {name_ff[23:0], in_byte};
                  len_in  = len_ff + 3'd1;
               end
            end
            PH_HASH: begin
               if (in_byte == CH_X_LO || in_byte == CH_X_UP) begin
                  phase_in = PH_HEX;
               end else if (dig_ok) begin
                  digit_in = 1'b1;
                  code_in  = acc_next[20:0];
                  phase_in = PH_DEC;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_DEC, PH_HEX: begin
               if (in_byte == CH_SEMI) begin
                  if (!digit_ff || ovf_ff || code_ff == 21'd0 ||
                      (code_ff >= CP_SURR_LO && code_ff <= CP_SURR_HI)) begin
                     phase_in = PH_FAIL;
                  end else begin
                     push_valid    = 1'b1;
                     push_job.kind = JOB_CODE;
                     push_job.value = code_ff;
                     phase_in      = PH_PLAIN;
                     code_in       = '0;
                     ovf_in        = 1'b0;
                     digit_in      = 1'b0;
                  end
               end else if (dig_ok) begin
                  digit_in = 1'b1;
                  if (ovf_ff || acc_next > {4'd0, CP_MAX}) begin
                     ovf_in = 1'b1;
                  end else begin
                     code_in = acc_next[20:0];
                  end
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            default: begin
               if (in_byte == CH_AMP) begin
                  phase_in = PH_NAME;
                  name_in  = '0;
                  len_in   = '0;
                  code_in  = '0;
                  ovf_in   = 1'b0;
                  digit_in = 1'b0;
               end else begin
                  push_valid = 1'b1;
               end
            end
         endcase

         if (is_last) begin
            if (phase_in != PH_PLAIN) begin
               push_valid = 1'b1;
               push_job   = '{kind: JOB_ERROR, value: 21'd0, last: 1'b1};
            end else begin
               push_job.last = 1'b1;
            end
            phase_in = PH_PLAIN;
            name_in  = '0;
            len_in   = '0;
            code_in  = '0;
            ovf_in   = 1'b0;
            digit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         name_ff  <= '0;
         len_ff   <= '0;
         code_ff  <= '0;
         ovf_ff   <= 1'b0;
         digit_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         name_ff  <= name_in;
         len_ff   <= len_in;
         code_ff  <= code_in;
         ovf_ff   <= ovf_in;
         digit_ff <= digit_in;
      end
   end

endmodule

// ----- rtl/core/xed_queue.sv -----
// Job queue between parser front end and UTF-8 back end.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_queue #(
   parameter int QUEUE_DEPTH = xed_pkg::XED_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xed_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output xed_pkg::job_type head_job
);
   import xed_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/xed_back.sv -----
// Back end: expands queued jobs into result bytes, UTF-8 for code points,
// through an output register. Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  xed_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_decode_error,
   output logic             rsp_run_last
);
   import xed_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, bval_in;
   logic       err_ff,  err_in;
   logic       last_ff, last_in;

   logic [1:0] span;
   logic       final_byte;
   logic       load;

   always_comb begin
      span = 2'd0;
      if (head_job.kind == JOB_CODE) begin
         span = utf8_span(head_job.value);
      end
      final_byte = (idx_ff == span);
      load       = head_valid && (!valid_ff || !rsp_stall);
      pop        = load && final_byte;

      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      bval_in  = bval_ff;
      err_in   = err_ff;
      last_in  = last_ff;

      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_byte ? 2'd0 : idx_ff + 2'd1;
         last_in  = head_job.last && final_byte;
         case (head_job.kind)
            JOB_ERROR: begin
               byte_in = 8'd0;
               bval_in = 1'b0;
               err_in  = 1'b1;
            end
            JOB_CODE: begin
               byte_in = utf8_byte(head_job.value, span, idx_ff);
               bval_in = 1'b1;
               err_in  = 1'b0;
            end
            default: begin
               byte_in = head_job.value[7:0];
               bval_in = 1'b1;
               err_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bval_ff;
   assign rsp_decode_error = err_ff;
   assign rsp_run_last     = last_ff;

endmodule

// ----- rtl/core/xml_entity_decoder_utf8_core.sv -----
// Top level of the XML entity decoder with UTF-8 output.
// Depends on xed_pkg, xed_front, xed_queue, xed_back.
//
//   channel | ports                                        | direction
//   req     | req_valid, req_stall, req_in_byte, req_is_last | in (stall out)
//   rsp     | rsp_valid, rsp_stall, rsp_out_byte,          | out (stall in)
//           | rsp_byte_valid, rsp_decode_error, rsp_run_last |
//
// One input byte per cycle while req_stall is low; the parser writes at most one
// job per byte into the job queue. A numeric reference expands to 1 to 4 result
// bytes, one per cycle from the back end while rsp_stall is low; its job stays
// at the queue head until its final byte is loaded. req_stall is high while the
// job queue is full. A byte's first result passes the job queue and the output
// register. Reset is synchronous and clears parser state, queue and output valid.
`timescale 1ns / 1ps

module xml_entity_decoder_utf8_core #(
   parameter int QUEUE_DEPTH = xed_pkg::XED_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_decode_error,
   output logic       rsp_run_last
);
   import xed_pkg::*;

   logic    accept;
   logic    push_valid;
   job_type push_job;
   logic    full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   xed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .is_last    (req_is_last),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   xed_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   xed_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_decode_error (rsp_decode_error),
      .rsp_run_last     (rsp_run_last)
   );

endmodule
